// ----- rtl/mtsl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtsl_pkg
// Shared types and constants for the two-list merge block.
// ---------------------------------------------------------------------------
package mtsl_pkg;

  // Element width and default list capacity
  localparam int DATA_W          = 32;
  localparam int LIST_DEPTH_DEF  = 32;

  // Bit positions inside in_tuser
  localparam int USER_SEL_BIT    = 0;
  localparam int USER_HAS_BIT    = 1;
  localparam int IN_USER_W       = 2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_PICK
  } mtsl_state_t;

  // Commands from the sequencer to one list store
  typedef struct packed {
    logic append;
    logic clear;
  } store_cmd_t;

endpackage

// ----- rtl/mtsl_list_store.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtsl_list_store
// One list: element memory with append at the fill count and a registered
// read port, plus the fill count itself.
// ---------------------------------------------------------------------------
module mtsl_list_store
  import mtsl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  store_cmd_t                        cmd,
  input  logic [DATA_W-1:0]                 wr_data,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   rd_addr,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   count,
  output logic                              full,
  output logic [DATA_W-1:0]                 rd_data
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  logic [DATA_W-1:0] mem [LIST_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              wr_en;

  assign full  = (count_r == DEPTH_C);
  assign wr_en = cmd.append && !full;

  // Advance the fill count on append, drop it back to zero on clear
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Write at the fill count, read at the head index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr[IDX_W-1:0]];
  end

  assign count   = count_r;
  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mtsl_merge_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtsl_merge_ctrl
// Load and merge sequencer: routes load beats to the stores, then walks both
// heads through the shared signed comparator and fills the output register.
// ---------------------------------------------------------------------------
module mtsl_merge_ctrl
  import mtsl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // load side
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_USER_W-1:0]              in_tuser,
  input  logic                              in_tlast,
  // store side
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   cnt_a,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   cnt_b,
  input  logic                              full_a,
  input  logic                              full_b,
  input  logic [DATA_W-1:0]                 rd_a,
  input  logic [DATA_W-1:0]                 rd_b,
  output store_cmd_t                        cmd_a,
  output store_cmd_t                        cmd_b,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   addr_a,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   addr_b,
  // result side
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [DATA_W-1:0]          out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  mtsl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_drop_r, out_drop_nxt;

  logic             in_acc;
  logic             sel_b;
  logic             has_el;
  logic             any_stored;
  logic             out_free;
  logic             a_avail;
  logic             b_avail;
  logic             pick_a;
  logic             do_pick;
  logic             last_pick;
  logic [CNT_W-1:0] i_adv;
  logic [CNT_W-1:0] j_adv;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign sel_b     = in_tuser[USER_SEL_BIT];
  assign has_el    = in_tuser[USER_HAS_BIT];

  // Anything to merge once this beat is stored
  assign any_stored = (cnt_a != '0) || (cnt_b != '0) || has_el;

  // Shared comparator: second list wins ties
  assign out_free  = !out_valid_r || out_tready;
  assign a_avail   = (i_r != cnt_a);
  assign b_avail   = (j_r != cnt_b);
  assign pick_a    = a_avail && (!b_avail || ($signed(rd_a) < $signed(rd_b)));
  assign do_pick   = (state_r == ST_PICK) && out_free;
  assign i_adv     = i_r + CNT_W'(pick_a);
  assign j_adv     = j_r + CNT_W'(!pick_a);
  assign last_pick = (i_adv == cnt_a) && (j_adv == cnt_b);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast && any_stored) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (do_pick) begin
          state_nxt = last_pick ? ST_LOAD : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Store commands, head indexes, overflow and output register
  always_comb begin
    cmd_a         = '0;
    cmd_b         = '0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cmd_a.append = has_el && !sel_b;
          cmd_b.append = has_el && sel_b;
          if (has_el && (sel_b ? full_b : full_a)) begin
            ovf_nxt = 1'b1;
          end
          // empty load closes with no result
          if (in_tlast && !any_stored) begin
            cmd_a.clear = 1'b1;
            cmd_b.clear = 1'b1;
            ovf_nxt     = 1'b0;
          end
        end
      end
      ST_FETCH: begin
      end
      ST_PICK: begin
        if (do_pick) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pick_a ? rd_a : rd_b;
          out_last_nxt  = last_pick;
          out_drop_nxt  = last_pick && ovf_r;
          i_nxt         = i_adv;
          j_nxt         = j_adv;
          if (last_pick) begin
            cmd_a.clear = 1'b1;
            cmd_b.clear = 1'b1;
            i_nxt       = '0;
            j_nxt       = '0;
            ovf_nxt     = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      i_r         <= '0;
      j_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload of the output register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign addr_a     = i_r;
  assign addr_b     = j_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

endmodule

// ----- rtl/merge_two_sorted_lists.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// merge_two_sorted_lists
// Loads two ascending lists of signed values and streams out their merge.
// ---------------------------------------------------------------------------
// Load beats are taken one per cycle; each beat names its list in in_tuser
// and may carry no element, and the beat with in_tlast closes the load. The
// block then stops taking beats and emits the merged ascending sequence, the
// second list's element first on equal heads, with out_tlast on the final
// value and out_tuser set there if any element overflowed a list of
// LIST_DEPTH entries. Each result passes a fetch state, which reads both
// list heads from the registered memory ports, and a pick state for the
// shared compare, held by output stalls. A load that closes with both lists
// empty gives no result. Loading resumes in the cycle after the final value
// is picked, even while that value still waits in the output register.
// ---------------------------------------------------------------------------
module merge_two_sorted_lists
  import mtsl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // load channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic signed [DATA_W-1:0]  in_tdata,   // element
  input  logic [IN_USER_W-1:0]      in_tuser,   // [0] list_select, [1] has_element
  input  logic                      in_tlast,   // load_done
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic signed [DATA_W-1:0]  out_tdata,  // merged_value
  output logic                      out_tuser,  // [0] dropped_flag
  output logic                      out_tlast   // is_last
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  store_cmd_t        cmd_a, cmd_b;
  logic [CNT_W-1:0]  cnt_a, cnt_b;
  logic [CNT_W-1:0]  addr_a, addr_b;
  logic              full_a, full_b;
  logic [DATA_W-1:0] rd_a, rd_b;

  // First list
  mtsl_list_store #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_a),
    .wr_data (in_tdata),
    .rd_addr (addr_a),
    .count   (cnt_a),
    .full    (full_a),
    .rd_data (rd_a)
  );

  // Second list
  mtsl_list_store #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_b),
    .wr_data (in_tdata),
    .rd_addr (addr_b),
    .count   (cnt_b),
    .full    (full_b),
    .rd_data (rd_b)
  );

  // Sequencer and shared comparator
  mtsl_merge_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cnt_a      (cnt_a),
    .cnt_b      (cnt_b),
    .full_a     (full_a),
    .full_b     (full_b),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .cmd_a      (cmd_a),
    .cmd_b      (cmd_b),
    .addr_a     (addr_a),
    .addr_b     (addr_b),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
